[sv/ipsba_pkg.sv]
// shared types and constants for the per-source ipv4 byte accounting block
package ipsba_pkg;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 128;

    localparam logic [7:0]  ETH2_MIN_TYPE = 8'h06;
    localparam logic [7:0]  RAW_MARK      = 8'hFF;
    localparam logic [7:0]  SNAP_SAP      = 8'hAA;
    localparam logic [7:0]  UI_CONTROL    = 8'h03;
    localparam logic [7:0]  IPV4_TYPE_HI  = 8'h08;
    localparam logic [7:0]  IPV4_TYPE_LO  = 8'h00;
    localparam logic [7:0]  VERSION_MASK  = 8'hF0;
    localparam logic [7:0]  VERSION_IPV4  = 8'h40;
    localparam logic [16:0] MIN_WIRE_LEN  = 17'd64;
    localparam logic [16:0] FCS_BYTES     = 17'd4;
    localparam logic [31:0] TOTAL_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_ETH2 = 2'd0,
        KIND_RAW  = 2'd1,
        KIND_SNAP = 2'd2,
        KIND_LLC  = 2'd3
    } kind_t;

    // one header as it walks down the cell row
    typedef struct packed {
        kind_t       frame_kind;
        logic [16:0] wire_length;
        logic        is_ipv4;
        logic [31:0] source_address;
        logic [15:0] captured_length;
        logic        found;
        logic        host_new;
        logic [31:0] host_total;
    } item_t;

endpackage

[sv/ipsba_front.sv]
// header classification and wire length ahead of the cell row
module ipsba_front (
    input  logic [ipsba_pkg::S_DATA_W-1:0] s_word,
    output ipsba_pkg::item_t               item
);

    logic [7:0]  type_high;
    logic [7:0]  type_low;
    logic [7:0]  byte_fourteen;
    logic [7:0]  byte_fifteen;
    logic [7:0]  byte_sixteen;
    logic [31:0] source_address;
    logic [15:0] captured_length;
    logic [16:0] wire_sum;

    assign type_high       = s_word[7:0];
    assign type_low        = s_word[15:8];
    assign byte_fourteen   = s_word[23:16];
    assign byte_fifteen    = s_word[31:24];
    assign byte_sixteen    = s_word[39:32];
    assign source_address  = s_word[71:40];
    assign captured_length = s_word[87:72];

    assign wire_sum = 17'(captured_length) + ipsba_pkg::FCS_BYTES;

    always_comb begin
        item = '0;
        if (type_high >= ipsba_pkg::ETH2_MIN_TYPE) begin
            item.frame_kind = ipsba_pkg::KIND_ETH2;
        end else if (byte_fourteen == ipsba_pkg::RAW_MARK
                     && byte_fifteen == ipsba_pkg::RAW_MARK) begin
            item.frame_kind = ipsba_pkg::KIND_RAW;
        end else if (byte_fourteen == ipsba_pkg::SNAP_SAP
                     && byte_fifteen == ipsba_pkg::SNAP_SAP
                     && byte_sixteen == ipsba_pkg::UI_CONTROL) begin
            item.frame_kind = ipsba_pkg::KIND_SNAP;
        end else begin
            item.frame_kind = ipsba_pkg::KIND_LLC;
        end
        item.wire_length = (wire_sum < ipsba_pkg::MIN_WIRE_LEN) ?
                           ipsba_pkg::MIN_WIRE_LEN : wire_sum;
        item.is_ipv4 = (type_high == ipsba_pkg::IPV4_TYPE_HI)
                    && (type_low == ipsba_pkg::IPV4_TYPE_LO)
                    && ((byte_fourteen & ipsba_pkg::VERSION_MASK)
                        == ipsba_pkg::VERSION_IPV4);
        item.source_address  = source_address;
        item.captured_length = captured_length;
    end

endmodule

[sv/ipsba_cell.sv]
// one table slot: holds a source and its total, passes the header on each cycle that the row advances
module ipsba_cell #(
    parameter int TABLE_ENTRIES = 64,
    parameter int CELL_INDEX    = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]   entry_count,
    input  logic                                 vld_in,
    input  ipsba_pkg::item_t                     item_in,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     slot_in,
    output logic                                 vld_out,
    output ipsba_pkg::item_t                     item_out,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     slot_out,
    output logic                                 claim
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0]  IDX_CNT  = CNT_W'(CELL_INDEX);
    localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(CELL_INDEX);

    logic [31:0]       addr_reg;
    logic [31:0]       total_reg;
    logic              vld_reg;
    ipsba_pkg::item_t  item_reg;
    ipsba_pkg::item_t  item_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    logic        searching;
    logic        hit;
    logic [32:0] sum;
    logic [31:0] sat_total;

    // slots below the fill count are occupied
    assign searching = vld_in && item_in.is_ipv4 && !item_in.found && !item_in.host_new;
    assign hit       = searching && (IDX_CNT < entry_count)
                    && (addr_reg == item_in.source_address);
    assign claim     = searching && (entry_count == IDX_CNT);

    assign sum       = {1'b0, total_reg} + 33'(item_in.captured_length);
    assign sat_total = sum[32] ? ipsba_pkg::TOTAL_MAX : sum[31:0];

    always_comb begin
        item_next = item_in;
        slot_next = slot_in;
        if (hit) begin
            item_next.found      = 1'b1;
            item_next.host_total = sat_total;
            slot_next            = IDX_SLOT;
        end else if (claim) begin
            item_next.host_new   = 1'b1;
            item_next.host_total = 32'(item_in.captured_length);
            slot_next            = IDX_SLOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
            slot_reg <= slot_next;
            if (hit) begin
                total_reg <= sat_total;
            end else if (claim) begin
                addr_reg  <= item_in.source_address;
                total_reg <= 32'(item_in.captured_length);
            end
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;
    assign slot_out = slot_reg;

endmodule

[sv/ipsba_tail.sv]
// top sender tracking and output register at the end of the cell row
module ipsba_tail #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               vld_in,
    input  ipsba_pkg::item_t                   item_in,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   slot_in,
    output logic                               advance,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ipsba_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);

    logic [SLOT_W-1:0]             best_slot_reg;
    logic [SLOT_W-1:0]             best_slot_next;
    logic [31:0]                   best_total_reg;
    logic [31:0]                   best_total_next;
    logic [31:0]                   top_addr_reg;
    logic [31:0]                   top_addr_next;
    logic                          m_tvalid_reg;
    logic [ipsba_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [ipsba_pkg::M_DATA_W-1:0] m_tdata_next;

    logic              counted;
    logic              dropped;
    logic              take_best;
    logic              top_valid;
    logic [SLOT_W+5:0] slot_ext;
    logic [5:0]        host_slot;

    assign advance = !m_tvalid_reg || m_tready;

    assign counted = item_in.found || item_in.host_new;
    assign dropped = item_in.is_ipv4 && !counted;

    // ties go to the lower slot; the current top always follows its own total
    assign take_best = vld_in && counted
                    && (slot_in == best_slot_reg
                        || item_in.host_total > best_total_reg
                        || (item_in.host_total == best_total_reg
                            && slot_in < best_slot_reg));

    always_comb begin
        best_slot_next  = best_slot_reg;
        best_total_next = best_total_reg;
        top_addr_next   = top_addr_reg;
        if (take_best) begin
            best_slot_next  = slot_in;
            best_total_next = item_in.host_total;
            top_addr_next   = item_in.source_address;
        end
    end

    assign top_valid = (best_total_next != 32'd0);
    assign slot_ext  = {6'd0, slot_in};
    assign host_slot = counted ? slot_ext[5:0] : 6'd0;

    always_comb begin
        m_tdata_next = {3'd0,
                        top_valid,
                        top_valid ? best_total_next : 32'd0,
                        top_valid ? top_addr_next : 32'd0,
                        item_in.host_total,
                        dropped,
                        item_in.host_new,
                        host_slot,
                        item_in.is_ipv4,
                        item_in.wire_length,
                        2'(item_in.frame_kind)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            best_slot_reg  <= '0;
            best_total_reg <= 32'd0;
        end else if (advance) begin
            m_tvalid_reg   <= vld_in;
            best_slot_reg  <= best_slot_next;
            best_total_reg <= best_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            top_addr_reg <= top_addr_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_new_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[26] && m_tdata_reg[27]))
        else $error("new entry and drop flagged on the same word");

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> best_total_reg >= $past(best_total_reg))
        else $error("top total went down");

    a_counted_is_ipv4: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_in && counted) |-> item_in.is_ipv4)
        else $error("non-ipv4 header was counted");
`endif

endmodule

[sv/ipv4_source_byte_accounting.sv]
// top level: frame classifier, row of source cells and top sender tracker
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid / s_tready  s_tdata, one frame header summary
//   m_       out  m_tvalid / m_tready  m_tdata, one result per header
//
// one header per cycle while the row is not stalled; each header walks one cell per
// cycle while the row advances, so with the output register there are TABLE_ENTRIES
// + 1 stages, the cell registers in order and then the output register
// reset clears the fill count, the top total and slot and the valid bits; stored
// addresses and totals are not cleared, slots beyond the fill count are ignored
// a result word held by m_tready low freezes the whole row and drops s_tready
// in the same cycle
module ipv4_source_byte_accounting #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // type_high, type_low, byte_fourteen, byte_fifteen, byte_sixteen,
    // source_address, captured_length
    input  logic [ipsba_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // frame_kind, wire_length, is_ipv4, host_slot, host_new, host_dropped,
    // host_total, top_address, top_total, top_valid, zero pad
    output logic [ipsba_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    logic                       advance;
    logic [CNT_W-1:0]           count_reg;
    logic [TABLE_ENTRIES-1:0]   claim_vec;
    logic                       vld_w  [0:TABLE_ENTRIES];
    ipsba_pkg::item_t           item_w [0:TABLE_ENTRIES];
    logic [SLOT_W-1:0]          slot_w [0:TABLE_ENTRIES];

    ipsba_front u_front (
        .s_word (s_tdata),
        .item   (item_w[0])
    );

    assign vld_w[0]  = s_tvalid;
    assign slot_w[0] = '0;
    assign s_tready  = advance;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ipsba_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_INDEX    (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (advance),
            .entry_count (count_reg),
            .vld_in      (vld_w[i]),
            .item_in     (item_w[i]),
            .slot_in     (slot_w[i]),
            .vld_out     (vld_w[i+1]),
            .item_out    (item_w[i+1]),
            .slot_out    (slot_w[i+1]),
            .claim       (claim_vec[i])
        );
    end

    // only the cell at the fill count can take a new source
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (advance && (|claim_vec)) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    ipsba_tail #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .vld_in   (vld_w[TABLE_ENTRIES]),
        .item_in  (item_w[TABLE_ENTRIES]),
        .slot_in  (slot_w[TABLE_ENTRIES]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_single_claim: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(claim_vec))
        else $error("more than one cell took a new source");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> count_reg == $past(count_reg))
        else $error("fill count moved while the row was stalled");
`endif

endmodule
